FILE: rtl/i2cm_pkg.sv
package i2cm_pkg;

    localparam int CFG_WIDTH = 16;
    localparam logic [CFG_WIDTH-1:0] HALF_PERIOD_RESET = 16'd5;
    localparam int APB_ADDR_WIDTH = 2;
    localparam logic [APB_ADDR_WIDTH-1:0] ADDR_HALF_PERIOD = 2'd0;

    localparam logic [1:0] KIND_WRITE = 2'd1;
    localparam logic [1:0] KIND_READ  = 2'd2;

    localparam logic [3:0] BITS_PER_BYTE = 4'd8;

    typedef enum logic [1:0] {
        CMD_NONE  = 2'd0,
        CMD_WRITE = 2'd1,
        CMD_READ  = 2'd2
    } cmd_t;

    typedef struct packed {
        cmd_t       cmd;
        logic       start_cond;
        logic       stop_cond;
        logic [7:0] tx_byte;
        logic       ack_to_send;
        logic       scl_level;
        logic       sda_level;
    } item_t;

endpackage

FILE: rtl/i2c_byte_master.sv
// Open-drain I2C master moving one byte per command. Each transaction on the
// s_ channel is one sampled tick of SCL and SDA, optionally carrying a write or
// read command while idle; each tick yields exactly one m_ transaction with the
// pull-low drives, busy, done and the last received byte and ACK status. One
// tick is taken every clock cycle unless m_ready back-pressure stalls it: the
// single-cycle bus state machine in the engine sets that rate. A tick's result
// is offered on the m_ channel after it passes through the two-entry input
// queue and the engine then loads the output register. half_period_ticks sets
// the length of each delay step in ticks and is written through the APB port at
// address 0; the user must do so only while idle, the block does not enforce it.
module i2c_byte_master #(
    parameter int DELAY_WIDTH = 16
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [i2cm_pkg::APB_ADDR_WIDTH-1:0] paddr,
    input  logic [31:0]                         pwdata,
    output logic [31:0]                         prdata,
    output logic                                pready,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [1:0]                          s_kind,
    input  logic                                s_start_cond,
    input  logic                                s_stop_cond,
    input  logic [7:0]                          s_tx_byte,
    input  logic                                s_ack_to_send,
    input  logic                                s_scl_level,
    input  logic                                s_sda_level,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic                                m_scl_pull_low,
    output logic                                m_sda_pull_low,
    output logic                                m_busy_res,
    output logic                                m_done_res,
    output logic [7:0]                          m_rx_byte,
    output logic                                m_nack_seen
);
    import i2cm_pkg::*;

    logic [CFG_WIDTH-1:0] half_period_reg, half_period_next;
    logic                 cfg_write;
    logic                 q_valid;
    logic                 q_ready;
    item_t                q_item;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready && (paddr == ADDR_HALF_PERIOD);
    assign prdata    = (paddr == ADDR_HALF_PERIOD) ? 32'(half_period_reg) : 32'd0;

    always_comb begin
        half_period_next = half_period_reg;
        if (cfg_write) begin
            half_period_next = pwdata[CFG_WIDTH-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            half_period_reg <= HALF_PERIOD_RESET;
        end else begin
            half_period_reg <= half_period_next;
        end
    end

    i2cm_front u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_kind        (s_kind),
        .s_start_cond  (s_start_cond),
        .s_stop_cond   (s_stop_cond),
        .s_tx_byte     (s_tx_byte),
        .s_ack_to_send (s_ack_to_send),
        .s_scl_level   (s_scl_level),
        .s_sda_level   (s_sda_level),
        .q_valid       (q_valid),
        .q_ready       (q_ready),
        .q_item        (q_item)
    );

    i2cm_engine #(
        .DELAY_WIDTH (DELAY_WIDTH)
    ) u_engine (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .half_period_ticks (half_period_reg),
        .q_valid           (q_valid),
        .q_ready           (q_ready),
        .q_item            (q_item),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_scl_pull_low    (m_scl_pull_low),
        .m_sda_pull_low    (m_sda_pull_low),
        .m_busy_res        (m_busy_res),
        .m_done_res        (m_done_res),
        .m_rx_byte         (m_rx_byte),
        .m_nack_seen       (m_nack_seen)
    );

endmodule

FILE: rtl/i2cm_front.sv
module i2cm_front (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  logic [1:0]       s_kind,
    input  logic             s_start_cond,
    input  logic             s_stop_cond,
    input  logic [7:0]       s_tx_byte,
    input  logic             s_ack_to_send,
    input  logic             s_scl_level,
    input  logic             s_sda_level,
    output logic             q_valid,
    input  logic             q_ready,
    output i2cm_pkg::item_t  q_item
);
    import i2cm_pkg::*;

    localparam int DEPTH = 2;

    item_t       entry_reg [DEPTH];
    logic        wr_ptr_reg, wr_ptr_next;
    logic        rd_ptr_reg, rd_ptr_next;
    logic [1:0]  count_reg, count_next;
    item_t       item_in;
    logic        push;
    logic        pop;

    // decode the command kind; reserved kind is a plain tick
    always_comb begin
        item_in.cmd         = CMD_NONE;
        if (s_kind == KIND_WRITE) begin
            item_in.cmd = CMD_WRITE;
        end else if (s_kind == KIND_READ) begin
            item_in.cmd = CMD_READ;
        end
        item_in.start_cond  = s_start_cond;
        item_in.stop_cond   = s_stop_cond;
        item_in.tx_byte     = s_tx_byte;
        item_in.ack_to_send = s_ack_to_send;
        item_in.scl_level   = s_scl_level;
        item_in.sda_level   = s_sda_level;
    end

    assign s_ready = (count_reg != 2'(DEPTH));
    assign q_valid = (count_reg != 2'd0);
    assign q_item  = entry_reg[rd_ptr_reg];
    assign push    = s_valid && s_ready;
    assign pop     = q_valid && q_ready;

    always_comb begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 2'd1;
        end else if (pop && !push) begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= item_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

FILE: rtl/i2cm_engine.sv
module i2cm_engine #(
    parameter int DELAY_WIDTH = 16
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic [i2cm_pkg::CFG_WIDTH-1:0] half_period_ticks,
    input  logic                           q_valid,
    output logic                           q_ready,
    input  i2cm_pkg::item_t                q_item,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic                           m_scl_pull_low,
    output logic                           m_sda_pull_low,
    output logic                           m_busy_res,
    output logic                           m_done_res,
    output logic [7:0]                     m_rx_byte,
    output logic                           m_nack_seen
);
    import i2cm_pkg::*;

    localparam logic [31:0] DELAY_MAX = {32{1'b1}} >> (32 - DELAY_WIDTH);

    typedef enum logic [12:0] {
        PH_IDLE    = 13'b0000000000001,
        PH_ST_D1   = 13'b0000000000010,
        PH_ST_WAIT = 13'b0000000000100,
        PH_ST_D2   = 13'b0000000001000,
        PH_ST_D3   = 13'b0000000010000,
        PH_BIT_D1  = 13'b0000000100000,
        PH_BIT_WT  = 13'b0000001000000,
        PH_BIT_D2  = 13'b0000010000000,
        PH_BIT_D3  = 13'b0000100000000,
        PH_SP_D1   = 13'b0001000000000,
        PH_SP_WAIT = 13'b0010000000000,
        PH_SP_D2   = 13'b0100000000000,
        PH_SP_D3   = 13'b1000000000000
    } phase_t;

    phase_t                 phase_reg, phase_next;
    logic [3:0]             bit_count_reg, bit_count_next;
    logic [7:0]             shift_reg, shift_next;
    logic [DELAY_WIDTH-1:0] delay_count_reg, delay_count_next;
    logic                   open_reg, open_next;
    logic                   pending_stop_reg, pending_stop_next;
    logic                   pending_ack_reg, pending_ack_next;
    logic                   is_read_reg, is_read_next;
    logic                   scl_drive_reg, scl_drive_next;
    logic                   sda_drive_reg, sda_drive_next;
    logic                   last_nack_reg, last_nack_next;
    logic [7:0]             last_rx_reg, last_rx_next;
    logic                   m_valid_reg, m_valid_next;
    logic                   done_next;

    logic [31:0]            hp_wide;
    logic [31:0]            lim_wide;
    logic [DELAY_WIDTH-1:0] delay_limit;
    logic [DELAY_WIDTH-1:0] delay_inc;
    logic                   step_done;
    logic                   slot_reads_now;
    logic                   slot_reads_next;
    logic                   do_enter;
    logic                   pop;

    assign pop     = q_valid && q_ready;
    assign q_ready = !m_valid_reg || m_ready;
    assign m_valid = m_valid_reg;

    // delay step length, saturated to the counter range and at least one tick
    always_comb begin
        hp_wide  = 32'(half_period_ticks);
        lim_wide = (hp_wide > DELAY_MAX) ? DELAY_MAX : hp_wide;
        delay_limit = lim_wide[DELAY_WIDTH-1:0];
        if (delay_limit == '0) begin
            delay_limit = DELAY_WIDTH'(1);
        end
    end

    assign delay_inc      = delay_count_reg + DELAY_WIDTH'(1);
    assign step_done      = (delay_inc >= delay_limit);
    assign slot_reads_now = is_read_reg ? (bit_count_reg < BITS_PER_BYTE)
                                        : (bit_count_reg == BITS_PER_BYTE);

    always_comb begin
        phase_next        = phase_reg;
        bit_count_next    = bit_count_reg;
        shift_next        = shift_reg;
        delay_count_next  = delay_count_reg;
        open_next         = open_reg;
        pending_stop_next = pending_stop_reg;
        pending_ack_next  = pending_ack_reg;
        is_read_next      = is_read_reg;
        scl_drive_next    = scl_drive_reg;
        sda_drive_next    = sda_drive_reg;
        last_nack_next    = last_nack_reg;
        last_rx_next      = last_rx_reg;
        done_next         = 1'b0;
        do_enter          = 1'b0;
        slot_reads_next   = 1'b0;

        if (pop) begin
            unique case (phase_reg)
                PH_IDLE: begin
                    if (q_item.cmd != CMD_NONE) begin
                        is_read_next      = (q_item.cmd == CMD_READ);
                        pending_stop_next = q_item.stop_cond;
                        pending_ack_next  = q_item.ack_to_send;
                        shift_next        = (q_item.cmd == CMD_READ) ? 8'd0 : q_item.tx_byte;
                        bit_count_next    = 4'd0;
                        delay_count_next  = '0;
                        if (q_item.cmd == CMD_WRITE && q_item.start_cond) begin
                            if (open_reg) begin
                                sda_drive_next = 1'b0;
                                phase_next     = PH_ST_D1;
                            end else begin
                                sda_drive_next = 1'b1;
                                phase_next     = PH_ST_D3;
                            end
                            open_next = 1'b1;
                        end else begin
                            do_enter = 1'b1;
                        end
                    end
                end
                PH_ST_D1, PH_BIT_D1, PH_SP_D1: begin
                    delay_count_next = step_done ? '0 : delay_inc;
                    if (step_done) begin
                        scl_drive_next = 1'b0;
                        unique case (phase_reg)
                            PH_ST_D1:  phase_next = PH_ST_WAIT;
                            PH_BIT_D1: phase_next = PH_BIT_WT;
                            default:   phase_next = PH_SP_WAIT;
                        endcase
                    end
                end
                PH_ST_WAIT: begin
                    if (q_item.scl_level) begin
                        delay_count_next = '0;
                        phase_next       = PH_ST_D2;
                    end
                end
                PH_ST_D2: begin
                    delay_count_next = step_done ? '0 : delay_inc;
                    if (step_done) begin
                        sda_drive_next = 1'b1;
                        phase_next     = PH_ST_D3;
                    end
                end
                PH_ST_D3: begin
                    delay_count_next = step_done ? '0 : delay_inc;
                    if (step_done) begin
                        scl_drive_next = 1'b1;
                        do_enter       = 1'b1;
                    end
                end
                PH_BIT_WT: begin
                    if (q_item.scl_level) begin
                        if (slot_reads_now) begin
                            if (is_read_reg) begin
                                shift_next = {shift_reg[6:0], q_item.sda_level};
                            end else begin
                                last_nack_next = q_item.sda_level;
                            end
                        end
                        delay_count_next = '0;
                        phase_next       = PH_BIT_D2;
                    end
                end
                PH_BIT_D2: begin
                    delay_count_next = step_done ? '0 : delay_inc;
                    if (step_done) begin
                        scl_drive_next = 1'b1;
                        phase_next     = PH_BIT_D3;
                    end
                end
                PH_BIT_D3: begin
                    delay_count_next = step_done ? '0 : delay_inc;
                    if (step_done) begin
                        if (!is_read_reg && bit_count_reg < BITS_PER_BYTE) begin
                            shift_next = {shift_reg[6:0], 1'b0};
                        end
                        bit_count_next = bit_count_reg + 4'd1;
                        if (is_read_reg && bit_count_next == BITS_PER_BYTE) begin
                            last_rx_next = shift_reg;
                        end
                        if (bit_count_next <= BITS_PER_BYTE) begin
                            do_enter = 1'b1;
                        end else if (pending_stop_reg) begin
                            sda_drive_next   = 1'b1;
                            delay_count_next = '0;
                            phase_next       = PH_SP_D1;
                        end else begin
                            phase_next = PH_IDLE;
                            done_next  = 1'b1;
                        end
                    end
                end
                PH_SP_WAIT: begin
                    if (q_item.scl_level) begin
                        delay_count_next = '0;
                        phase_next       = PH_SP_D2;
                    end
                end
                PH_SP_D2: begin
                    delay_count_next = step_done ? '0 : delay_inc;
                    if (step_done) begin
                        sda_drive_next = 1'b0;
                        phase_next     = PH_SP_D3;
                    end
                end
                PH_SP_D3: begin
                    delay_count_next = step_done ? '0 : delay_inc;
                    if (step_done) begin
                        open_next  = 1'b0;
                        phase_next = PH_IDLE;
                        done_next  = 1'b1;
                    end
                end
                default: begin
                    phase_next = PH_IDLE;
                end
            endcase

            // start of one bit slot: release sda to read, else drive the bit
            if (do_enter) begin
                slot_reads_next = is_read_next ? (bit_count_next < BITS_PER_BYTE)
                                               : (bit_count_next == BITS_PER_BYTE);
                if (slot_reads_next) begin
                    sda_drive_next = 1'b0;
                end else if (is_read_next) begin
                    sda_drive_next = ~pending_ack_next;
                end else begin
                    sda_drive_next = ~shift_next[7];
                end
                delay_count_next = '0;
                phase_next       = PH_BIT_D1;
            end
        end
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (pop) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            m_scl_pull_low <= scl_drive_next;
            m_sda_pull_low <= sda_drive_next;
            m_busy_res     <= (phase_next != PH_IDLE);
            m_done_res     <= done_next;
            m_rx_byte      <= last_rx_next;
            m_nack_seen    <= last_nack_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg        <= PH_IDLE;
            bit_count_reg    <= 4'd0;
            shift_reg        <= 8'd0;
            delay_count_reg  <= '0;
            open_reg         <= 1'b0;
            pending_stop_reg <= 1'b0;
            pending_ack_reg  <= 1'b0;
            is_read_reg      <= 1'b0;
            scl_drive_reg    <= 1'b0;
            sda_drive_reg    <= 1'b0;
            last_nack_reg    <= 1'b0;
            last_rx_reg      <= 8'd0;
            m_valid_reg      <= 1'b0;
        end else begin
            phase_reg        <= phase_next;
            bit_count_reg    <= bit_count_next;
            shift_reg        <= shift_next;
            delay_count_reg  <= delay_count_next;
            open_reg         <= open_next;
            pending_stop_reg <= pending_stop_next;
            pending_ack_reg  <= pending_ack_next;
            is_read_reg      <= is_read_next;
            scl_drive_reg    <= scl_drive_next;
            sda_drive_reg    <= sda_drive_next;
            last_nack_reg    <= last_nack_next;
            last_rx_reg      <= last_rx_next;
            m_valid_reg      <= m_valid_next;
        end
    end

endmodule

FILE: test/i2c_byte_master_test.sv
module i2c_byte_master_test;

    import i2cm_pkg::*;

    localparam logic [1:0] KIND_TICK     = CMD_NONE;
    localparam logic [1:0] KIND_RESERVED = 2'd3;
    localparam int ITEMS_PER_SETTING     = 160;

    typedef enum logic [4:0] {
        ENG_IDLE,
        ENG_RESTART_SETUP,
        ENG_RESTART_WAIT,
        ENG_START_HOLD,
        ENG_START_LOW,
        ENG_BIT_SETUP,
        ENG_BIT_WAIT,
        ENG_BIT_HIGH,
        ENG_BIT_LOW,
        ENG_STOP_SETUP,
        ENG_STOP_WAIT,
        ENG_STOP_HOLD,
        ENG_STOP_END
    } engine_phase_t;

    typedef struct packed {
        logic [1:0] kind;
        logic       start_cond;
        logic       stop_cond;
        logic [7:0] tx_byte;
        logic       ack_to_send;
        logic       scl_level;
        logic       sda_level;
    } bus_tick_t;

    typedef struct packed {
        logic       scl_pull_low;
        logic       sda_pull_low;
        logic       busy;
        logic       done;
        logic [7:0] rx_byte;
        logic       nack_seen;
    } line_result_t;

    typedef struct packed {
        bus_tick_t    tick;
        logic         stretchy;
        logic         pinned;
        line_result_t lines;
    } directed_row_t;

    localparam line_result_t LINES_IDLE = '0;
    localparam line_result_t START_PULLED = '{scl_pull_low: 1'b0, sda_pull_low: 1'b1,
        busy: 1'b1, done: 1'b0, rx_byte: 8'h00, nack_seen: 1'b0};

    logic                      aclk;
    logic                      aresetn = 1'b0;
    logic                      psel = 1'b0;
    logic                      penable = 1'b0;
    logic                      pwrite = 1'b0;
    logic [APB_ADDR_WIDTH-1:0] paddr = '0;
    logic [31:0]               pwdata = '0;
    logic [31:0]               prdata;
    logic                      pready;
    logic                      s_valid = 1'b0;
    logic                      s_ready;
    logic [1:0]                s_kind = '0;
    logic                      s_start_cond = 1'b0;
    logic                      s_stop_cond = 1'b0;
    logic [7:0]                s_tx_byte = '0;
    logic                      s_ack_to_send = 1'b0;
    logic                      s_scl_level = 1'b1;
    logic                      s_sda_level = 1'b1;
    logic                      m_valid;
    logic                      m_ready = 1'b1;
    logic                      m_scl_pull_low;
    logic                      m_sda_pull_low;
    logic                      m_busy_res;
    logic                      m_done_res;
    logic [7:0]                m_rx_byte;
    logic                      m_nack_seen;

    i2c_byte_master #(.DELAY_WIDTH(16)) dut (.*);

    // engine state as the block should hold it
    logic [CFG_WIDTH-1:0] half_period = HALF_PERIOD_RESET;
    engine_phase_t        eng_phase = ENG_IDLE;
    logic [3:0]           bit_idx = '0;
    logic [7:0]           shifter = '0;
    logic [15:0]          delay_cnt = '0;
    logic                 txn_open = 1'b0;
    logic                 stop_after = 1'b0;
    logic                 ack_bit = 1'b0;
    logic                 reading = 1'b0;
    logic                 scl_low = 1'b0;
    logic                 sda_low = 1'b0;
    logic                 nack_latched = 1'b0;
    logic [7:0]           rx_latched = '0;

    line_result_t  pending_lines[$];
    directed_row_t directed_rows[$];
    int            errors = 0;
    int            ticks_sent = 0;
    int            stretch_left = 0;
    logic          calm = 1'b0;
    logic          held_long = 1'b0;

    function automatic logic step_elapsed();
        logic [15:0] span;
        span = (half_period == '0) ? 16'd1 : half_period;
        delay_cnt = delay_cnt + 16'd1;
        if (delay_cnt >= span) begin
            delay_cnt = '0;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic logic slot_samples();
        return reading ? (bit_idx < BITS_PER_BYTE) : (bit_idx == BITS_PER_BYTE);
    endfunction

    function automatic void open_slot();
        if (slot_samples())
            sda_low = 1'b0;
        else
            sda_low = reading ? !ack_bit : !shifter[7];
        delay_cnt = '0;
        eng_phase = ENG_BIT_SETUP;
    endfunction

    function automatic line_result_t bus_engine_step(input bus_tick_t t);
        line_result_t r;
        logic finished;
        finished = 1'b0;
        case (eng_phase)
            ENG_IDLE: begin
                if (t.kind == KIND_WRITE || t.kind == KIND_READ) begin
                    reading = (t.kind == KIND_READ);
                    stop_after = t.stop_cond;
                    ack_bit = t.ack_to_send;
                    shifter = reading ? 8'h00 : t.tx_byte;
                    bit_idx = '0;
                    delay_cnt = '0;
                    if (!reading && t.start_cond) begin
                        if (txn_open) begin
                            sda_low = 1'b0;
                            eng_phase = ENG_RESTART_SETUP;
                        end else begin
                            sda_low = 1'b1;
                            eng_phase = ENG_START_LOW;
                        end
                        txn_open = 1'b1;
                    end else begin
                        open_slot();
                    end
                end
            end
            ENG_RESTART_SETUP: begin
                if (step_elapsed()) begin
                    scl_low = 1'b0;
                    eng_phase = ENG_RESTART_WAIT;
                end
            end
            ENG_RESTART_WAIT: begin
                if (t.scl_level) begin
                    delay_cnt = '0;
                    eng_phase = ENG_START_HOLD;
                end
            end
            ENG_START_HOLD: begin
                if (step_elapsed()) begin
                    sda_low = 1'b1;
                    eng_phase = ENG_START_LOW;
                end
            end
            ENG_START_LOW: begin
                if (step_elapsed()) begin
                    scl_low = 1'b1;
                    open_slot();
                end
            end
            ENG_BIT_SETUP: begin
                if (step_elapsed()) begin
                    scl_low = 1'b0;
                    eng_phase = ENG_BIT_WAIT;
                end
            end
            ENG_BIT_WAIT: begin
                if (t.scl_level) begin
                    if (slot_samples()) begin
                        if (reading)
                            shifter = {shifter[6:0], t.sda_level};
                        else
                            nack_latched = t.sda_level;
                    end
                    delay_cnt = '0;
                    eng_phase = ENG_BIT_HIGH;
                end
            end
            ENG_BIT_HIGH: begin
                if (step_elapsed()) begin
                    scl_low = 1'b1;
                    eng_phase = ENG_BIT_LOW;
                end
            end
            ENG_BIT_LOW: begin
                if (step_elapsed()) begin
                    if (!reading && bit_idx < BITS_PER_BYTE)
                        shifter = {shifter[6:0], 1'b0};
                    bit_idx = bit_idx + 4'd1;
                    if (reading && bit_idx == BITS_PER_BYTE)
                        rx_latched = shifter;
                    if (bit_idx <= BITS_PER_BYTE) begin
                        open_slot();
                    end else if (stop_after) begin
                        sda_low = 1'b1;
                        delay_cnt = '0;
                        eng_phase = ENG_STOP_SETUP;
                    end else begin
                        eng_phase = ENG_IDLE;
                        finished = 1'b1;
                    end
                end
            end
            ENG_STOP_SETUP: begin
                if (step_elapsed()) begin
                    scl_low = 1'b0;
                    eng_phase = ENG_STOP_WAIT;
                end
            end
            ENG_STOP_WAIT: begin
                if (t.scl_level) begin
                    delay_cnt = '0;
                    eng_phase = ENG_STOP_HOLD;
                end
            end
            ENG_STOP_HOLD: begin
                if (step_elapsed()) begin
                    sda_low = 1'b0;
                    eng_phase = ENG_STOP_END;
                end
            end
            ENG_STOP_END: begin
                if (step_elapsed()) begin
                    txn_open = 1'b0;
                    eng_phase = ENG_IDLE;
                    finished = 1'b1;
                end
            end
            default: begin
                eng_phase = ENG_IDLE;
            end
        endcase
        r.scl_pull_low = scl_low;
        r.sda_pull_low = sda_low;
        r.busy = (eng_phase != ENG_IDLE);
        r.done = finished;
        r.rx_byte = rx_latched;
        r.nack_seen = nack_latched;
        return r;
    endfunction

    // scl as the bus would show it, slave stretching now and then
    function automatic logic line_scl(input logic stretchy);
        if (scl_low)
            return 1'b0;
        if (eng_phase != ENG_RESTART_WAIT && eng_phase != ENG_BIT_WAIT
                && eng_phase != ENG_STOP_WAIT)
            return 1'b1;
        if (stretch_left != 0) begin
            stretch_left--;
            return 1'b0;
        end
        if (stretchy && $urandom_range(0, 7) == 0) begin
            stretch_left = $urandom_range(0, 30);
            return 1'b0;
        end
        return 1'b1;
    endfunction

    function automatic bus_tick_t random_tick(input logic cmds);
        bus_tick_t t;
        int pick;
        pick = $urandom_range(0, 9);
        t.kind = KIND_TICK;
        if (eng_phase != ENG_IDLE)
            t.kind = 2'($urandom_range(0, 3));
        else if (pick == 7)
            t.kind = KIND_RESERVED;
        else if (cmds && pick < 4)
            t.kind = KIND_WRITE;
        else if (cmds && pick < 7)
            t.kind = KIND_READ;
        t.start_cond = ($urandom_range(0, 2) != 0);
        t.stop_cond = ($urandom_range(0, 2) == 0);
        t.tx_byte = 8'($urandom_range(0, 255));
        t.ack_to_send = 1'($urandom_range(0, 1));
        t.sda_level = 1'($urandom_range(0, 1));
        t.scl_level = ($urandom_range(0, 19) == 0) ? 1'($urandom_range(0, 1))
                                                   : line_scl(1'b1);
        return t;
    endfunction

    function automatic directed_row_t row(input logic [1:0] kind, input logic start,
                                          input logic stop, input logic [7:0] data,
                                          input logic ack, input logic scl,
                                          input logic sda, input logic stretchy,
                                          input logic pinned, input line_result_t lines);
        directed_row_t d;
        d.tick = '{kind: kind, start_cond: start, stop_cond: stop, tx_byte: data,
                   ack_to_send: ack, scl_level: scl, sda_level: sda};
        d.stretchy = stretchy;
        d.pinned = pinned;
        d.lines = lines;
        return d;
    endfunction

    task automatic offer_tick(input bus_tick_t t, input logic pinned,
                              input line_result_t pinned_lines);
        line_result_t lines;
        int gap;
        if (!calm && $urandom_range(0, 19) == 0) begin
            gap = $urandom_range(1, 15);
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_kind <= t.kind;
        s_start_cond <= t.start_cond;
        s_stop_cond <= t.stop_cond;
        s_tx_byte <= t.tx_byte;
        s_ack_to_send <= t.ack_to_send;
        s_scl_level <= t.scl_level;
        s_sda_level <= t.sda_level;
        do @(posedge aclk); while (!s_ready);
        lines = bus_engine_step(t);
        pending_lines.push_back(pinned ? pinned_lines : lines);
        ticks_sent++;
    endtask

    task automatic write_reg(input logic [APB_ADDR_WIDTH-1:0] addr, input logic [31:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= value;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        half_period = value[CFG_WIDTH-1:0];
    endtask

    // finish the command in flight, then let every result drain
    task automatic settle();
        while (eng_phase != ENG_IDLE)
            offer_tick(random_tick(1'b1), 1'b0, LINES_IDLE);
        s_valid <= 1'b0;
        while (pending_lines.size() != 0)
            @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic run_setting(input logic [CFG_WIDTH-1:0] hp, input int count,
                               input logic cmds);
        write_reg(ADDR_HALF_PERIOD, {16'($urandom), hp});
        repeat (count) offer_tick(random_tick(cmds), 1'b0, LINES_IDLE);
        settle();
    endtask

    task automatic check_field(input string name, input logic [7:0] want,
                               input logic [7:0] got);
        if (got !== want) begin
            errors++;
            $display("%0t: %s expected %0h, got %0h", $time, name, want, got);
        end
    endtask

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        #5_000_000;
        $display("tb: failure");
        $finish;
    end

    always @(posedge aclk) begin
        line_result_t want;
        if (aresetn && m_valid === 1'b1 && m_ready) begin
            if (pending_lines.size() == 0) begin
                errors++;
                $display("%0t: result transaction with nothing expected", $time);
            end else begin
                want = pending_lines.pop_front();
                check_field("scl_pull_low", want.scl_pull_low, m_scl_pull_low);
                check_field("sda_pull_low", want.sda_pull_low, m_sda_pull_low);
                check_field("busy_res", want.busy, m_busy_res);
                check_field("done_res", want.done, m_done_res);
                check_field("rx_byte", want.rx_byte, m_rx_byte);
                check_field("nack_seen", want.nack_seen, m_nack_seen);
            end
        end
    end

    initial begin
        int gap;
        wait (aresetn);
        forever begin
            @(posedge aclk);
            if (!held_long && ticks_sent >= 1000) begin
                // long hold so the input queue fills and s_ready drops
                held_long = 1'b1;
                m_ready <= 1'b0;
                repeat (300) @(posedge aclk);
                m_ready <= 1'b1;
            end else if (!calm && $urandom_range(0, 15) == 0) begin
                gap = $urandom_range(1, 15);
                m_ready <= 1'b0;
                repeat (gap) @(posedge aclk);
                m_ready <= 1'b1;
            end
        end
    end

    initial begin
        bus_tick_t fill;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        if (prdata !== 32'(HALF_PERIOD_RESET)) begin
            errors++;
            $display("%0t: half_period_ticks expected %0h, got %0h", $time,
                     HALF_PERIOD_RESET, prdata);
        end
        write_reg(ADDR_HALF_PERIOD, 32'd1);

        // kind start stop byte ack scl sda stretch pinned lines
        directed_rows = '{
            row(KIND_TICK,     1'b0, 1'b0, 8'h00, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1, LINES_IDLE),
            row(KIND_TICK,     1'b1, 1'b1, 8'hFF, 1'b1, 1'b0, 1'b0, 1'b0, 1'b1, LINES_IDLE),
            row(KIND_RESERVED, 1'b1, 1'b1, 8'hFF, 1'b1, 1'b1, 1'b1, 1'b0, 1'b1, LINES_IDLE),
            row(KIND_WRITE,    1'b1, 1'b0, 8'hFF, 1'b0, 1'b1, 1'b0, 1'b0, 1'b1, START_PULLED),
            row(KIND_WRITE,    1'b0, 1'b0, 8'h00, 1'b0, 1'b1, 1'b1, 1'b0, 1'b0, LINES_IDLE),
            row(KIND_WRITE,    1'b1, 1'b1, 8'hA5, 1'b1, 1'b1, 1'b0, 1'b1, 1'b0, LINES_IDLE),
            row(KIND_READ,     1'b1, 1'b0, 8'h00, 1'b0, 1'b1, 1'b1, 1'b0, 1'b0, LINES_IDLE),
            row(KIND_READ,     1'b0, 1'b1, 8'hFF, 1'b1, 1'b1, 1'b0, 1'b1, 1'b0, LINES_IDLE),
            row(KIND_WRITE,    1'b0, 1'b1, 8'h5A, 1'b0, 1'b1, 1'b1, 1'b0, 1'b0, LINES_IDLE),
            row(KIND_WRITE,    1'b1, 1'b0, 8'h80, 1'b1, 1'b1, 1'b0, 1'b1, 1'b0, LINES_IDLE),
            row(KIND_READ,     1'b0, 1'b0, 8'h7F, 1'b1, 1'b1, 1'b1, 1'b0, 1'b0, LINES_IDLE),
            row(KIND_WRITE,    1'b1, 1'b1, 8'h01, 1'b0, 1'b1, 1'b1, 1'b1, 1'b0, LINES_IDLE),
            row(KIND_TICK,     1'b0, 1'b0, 8'h00, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0, LINES_IDLE)
        };

        // ticks that follow a command repeat it, so it must be ignored while busy
        foreach (directed_rows[i]) begin
            offer_tick(directed_rows[i].tick, directed_rows[i].pinned, directed_rows[i].lines);
            while (eng_phase != ENG_IDLE) begin
                fill = directed_rows[i].tick;
                fill.scl_level = line_scl(directed_rows[i].stretchy);
                offer_tick(fill, 1'b0, LINES_IDLE);
            end
        end
        settle();

        run_setting(16'd1, ITEMS_PER_SETTING, 1'b1);
        run_setting(16'd0, ITEMS_PER_SETTING, 1'b1);
        run_setting(16'hFFFF, 60, 1'b0);
        run_setting(16'd2, ITEMS_PER_SETTING, 1'b1);
        run_setting(16'd3, ITEMS_PER_SETTING, 1'b1);
        run_setting(16'($urandom_range(4, 9)), ITEMS_PER_SETTING, 1'b1);
        calm = 1'b1;
        run_setting(16'd1, ITEMS_PER_SETTING, 1'b1);

        repeat (10) @(posedge aclk);
        if (errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
